// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the rtl checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("concurrent assertion failed");

// assertion on the default clock and reset of this project
`define ASSERT_STD(name, prop) \
  `ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

// ===== rtl/btqm_pkg.sv =====
// ----------------------------------------------------------------------------
// btqm_pkg
// Types, sizes, operation codes and ring helpers of the bus transaction queue
// ----------------------------------------------------------------------------
package btqm_pkg;

  // sizing
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned BUS_COUNT   = 2;
  localparam int unsigned COOKIE_W    = 16;
  localparam int unsigned HANDLE_W    = 32;

  localparam int unsigned PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BUS_IDX_W = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
  localparam int unsigned ADDR_W    = BUS_IDX_W + PTR_W;
  localparam int unsigned RAM_DEPTH = 2 ** ADDR_W;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_QUEUE    = 2'd0,
    FUNC_CANCEL   = 2'd1,
    FUNC_COMPLETE = 2'd2,
    FUNC_RESERVE  = 2'd3
  } func_e;

  // result codes
  typedef enum logic [1:0] {
    RC_OK       = 2'd0,
    RC_NOTADDED = 2'd1,
    RC_BUSY     = 2'd2,
    RC_NOTFOUND = 2'd3
  } rc_e;

  // queue modes
  localparam logic [1:0] MODE_ADD       = 2'd0;
  localparam logic [1:0] MODE_IF_ABSENT = 2'd1;
  localparam logic [1:0] MODE_REPLACE   = 2'd2;

  // request from the sequencer to the entry memories
  typedef struct packed {
    logic                cookie_we;
    logic                handle_we;
    logic [ADDR_W-1:0]   waddr;
    logic [COOKIE_W-1:0] wcookie;
    logic [HANDLE_W-1:0] whandle;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

  // physical slot of a queue position, offset from the head modulo the depth
  function automatic logic [PTR_W-1:0] ring_pos(logic [PTR_W-1:0] head,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/btqm_ram.sv =====
// ----------------------------------------------------------------------------
// btqm_ram
// Generic simple dual-port RAM, one write and one registered read port
// ----------------------------------------------------------------------------
module btqm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/btqm_ctrl.sv =====
// ----------------------------------------------------------------------------
// btqm_ctrl
// Request sequencer: per-bus ring pointers, cookie scan, entry shift, results
// ----------------------------------------------------------------------------
module btqm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic                          bus_i,
  input  logic [15:0]                   cookie_i,
  input  logic [1:0]                    queue_mode_i,
  input  logic [31:0]                   descriptor_handle_i,
  input  logic [31:0]                   next_handle_i,
  input  logic                          status_i,
  input  logic [15:0]                   cookie_count_i,
  output logic                          done_o,
  output logic [1:0]                    result_code_o,
  output logic                          submit_valid_o,
  output logic [31:0]                   submit_handle_o,
  output logic [15:0]                   first_cookie_o,
  output logic                          retired_o,
  output logic                          skip_rest_o,
  output btqm_pkg::mem_req_t            mem_req_o,
  input  logic [btqm_pkg::COOKIE_W-1:0] rd_cookie_i,
  input  logic [btqm_pkg::HANDLE_W-1:0] rd_handle_i
);

  import btqm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_HEAD
  } st_e;

  st_e                 state_q, state_d;
  logic [CNT_W-1:0]    count_q [BUS_COUNT];
  logic [CNT_W-1:0]    count_d [BUS_COUNT];
  logic [PTR_W-1:0]    head_q  [BUS_COUNT];
  logic [PTR_W-1:0]    head_d  [BUS_COUNT];
  logic [COOKIE_W-1:0] nfc_q   [BUS_COUNT];
  logic [COOKIE_W-1:0] nfc_d   [BUS_COUNT];

  // latched request
  func_e               func_q, func_d;
  logic [BUS_IDX_W-1:0] bus_q, bus_d;
  logic [COOKIE_W-1:0] cookie_q, cookie_d;
  logic [1:0]          mode_q, mode_d;
  logic [HANDLE_W-1:0] desc_q, desc_d;
  logic                skip_q, skip_d;

  // scan and shift pointers
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [CNT_W-1:0]    pend_idx_q, pend_idx_d;

  // registered result
  logic                done_q, done_d;
  rc_e                 rc_q, rc_d;
  logic                sv_q, sv_d;
  logic [HANDLE_W-1:0] sh_q, sh_d;
  logic [COOKIE_W-1:0] fc_q, fc_d;
  logic                ret_q, ret_d;
  logic                skp_q, skp_d;

  // combinational helpers
  logic [BUS_IDX_W-1:0] bidx_in;
  logic [BUS_IDX_W-1:0] cur_bus;
  logic                 bus_ok;
  logic [CNT_W-1:0]     n;
  logic [PTR_W-1:0]     hd;
  logic                 match;
  logic                 fin;
  rc_e                  f_rc;
  logic                 f_sv;
  logic [HANDLE_W-1:0]  f_sh;
  logic [COOKIE_W-1:0]  f_fc;
  logic                 f_ret;
  logic                 f_skip;

  assign bidx_in = BUS_IDX_W'(bus_i);
  assign bus_ok  = (32'(bus_i) < BUS_COUNT);
  assign cur_bus = (state_q == ST_IDLE) ? bidx_in : bus_q;
  assign n       = count_q[cur_bus];
  assign hd      = head_q[cur_bus];
  assign match   = pend_q && (rd_cookie_i == cookie_q);
  assign busy    = (state_q != ST_IDLE);

  // next state, memory requests and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    nfc_d      = nfc_q;
    func_d     = func_q;
    bus_d      = bus_q;
    cookie_d   = cookie_q;
    mode_d     = mode_q;
    desc_d     = desc_q;
    skip_d     = skip_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    done_d     = 1'b0;
    rc_d       = rc_q;
    sv_d       = sv_q;
    sh_d       = sh_q;
    fc_d       = fc_q;
    ret_d      = ret_q;
    skp_d      = skp_q;

    fin    = 1'b0;
    f_rc   = RC_NOTFOUND;
    f_sv   = 1'b0;
    f_sh   = '0;
    f_fc   = '0;
    f_ret  = 1'b0;
    f_skip = 1'b0;

    mem_req_o           = '0;
    mem_req_o.wcookie   = cookie_q;
    mem_req_o.whandle   = desc_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          func_d   = func_e'(func_i);
          bus_d    = bidx_in;
          cookie_d = cookie_i;
          mode_d   = queue_mode_i;
          desc_d   = descriptor_handle_i;
          idx_d    = '0;
          pend_d   = 1'b0;
          if (!bus_ok) begin
            fin = 1'b1;
          end else begin
            case (func_e'(func_i))
              FUNC_QUEUE: begin
                if (queue_mode_i != MODE_ADD) begin
                  state_d = ST_SCAN;
                end else if (n >= CNT_W'(QUEUE_DEPTH)) begin
                  fin  = 1'b1;
                  f_rc = RC_BUSY;
                end else begin
                  // append at the tail
                  mem_req_o.cookie_we = 1'b1;
                  mem_req_o.handle_we = 1'b1;
                  mem_req_o.waddr     = {bidx_in, ring_pos(hd, n)};
                  mem_req_o.wcookie   = cookie_i;
                  mem_req_o.whandle   = descriptor_handle_i;
                  count_d[bidx_in]    = n + CNT_W'(1);
                  fin  = 1'b1;
                  f_rc = RC_OK;
                  if (n == '0) begin
                    f_sv = 1'b1;
                    f_sh = descriptor_handle_i;
                  end
                end
              end
              FUNC_CANCEL: begin
                if (n == '0) begin
                  fin = 1'b1;
                end else begin
                  state_d = ST_SCAN;
                end
              end
              FUNC_COMPLETE: begin
                if (n == '0) begin
                  fin = 1'b1;
                end else if (!status_i && (next_handle_i != '0)) begin
                  // head moves on to its next descriptor
                  mem_req_o.handle_we = 1'b1;
                  mem_req_o.waddr     = {bidx_in, hd};
                  mem_req_o.whandle   = next_handle_i;
                  fin  = 1'b1;
                  f_rc = RC_OK;
                  f_sv = 1'b1;
                  f_sh = next_handle_i;
                end else begin
                  // head retires, fetch the following entry if any
                  count_d[bidx_in] = n - CNT_W'(1);
                  head_d[bidx_in]  = ring_pos(hd, CNT_W'(1));
                  skip_d           = status_i && (next_handle_i != '0);
                  if (n > CNT_W'(1)) begin
                    mem_req_o.raddr = {bidx_in, ring_pos(hd, CNT_W'(1))};
                    state_d         = ST_HEAD;
                  end else begin
                    fin    = 1'b1;
                    f_rc   = RC_OK;
                    f_ret  = 1'b1;
                    f_skip = status_i && (next_handle_i != '0);
                  end
                end
              end
              FUNC_RESERVE: begin
                nfc_d[bidx_in] = nfc_q[bidx_in] + cookie_count_i;
                fin  = 1'b1;
                f_rc = RC_OK;
                f_fc = nfc_q[bidx_in];
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
        end
      end

      // pipelined cookie scan from the head, one read per cycle
      ST_SCAN: begin
        if (match) begin
          pend_d = 1'b0;
          if (func_q == FUNC_QUEUE) begin
            fin = 1'b1;
            if ((mode_q == MODE_REPLACE) && (pend_idx_q != '0)) begin
              mem_req_o.handle_we = 1'b1;
              mem_req_o.waddr     = {bus_q, ring_pos(hd, pend_idx_q)};
              f_rc = RC_OK;
            end else begin
              f_rc = RC_NOTADDED;
            end
          end else if (pend_idx_q == '0) begin
            fin  = 1'b1;
            f_rc = RC_BUSY;
          end else begin
            // close the gap behind the cancelled entry
            idx_d   = pend_idx_q + CNT_W'(1);
            state_d = ST_SHIFT;
          end
        end else if (idx_q < n) begin
          mem_req_o.raddr = {bus_q, ring_pos(hd, idx_q)};
          pend_d          = 1'b1;
          pend_idx_d      = idx_q;
          idx_d           = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          fin    = 1'b1;
          if (func_q == FUNC_QUEUE) begin
            if (n >= CNT_W'(QUEUE_DEPTH)) begin
              f_rc = RC_BUSY;
            end else begin
              mem_req_o.cookie_we = 1'b1;
              mem_req_o.handle_we = 1'b1;
              mem_req_o.waddr     = {bus_q, ring_pos(hd, n)};
              count_d[bus_q]      = n + CNT_W'(1);
              f_rc = RC_OK;
              if (n == '0) begin
                f_sv = 1'b1;
                f_sh = desc_q;
              end
            end
          end
        end
      end

      // move each later entry one place toward the head
      ST_SHIFT: begin
        if (pend_q) begin
          mem_req_o.cookie_we = 1'b1;
          mem_req_o.handle_we = 1'b1;
          mem_req_o.waddr     = {bus_q, ring_pos(hd, pend_idx_q)};
          mem_req_o.wcookie   = rd_cookie_i;
          mem_req_o.whandle   = rd_handle_i;
        end
        if (idx_q < n) begin
          mem_req_o.raddr = {bus_q, ring_pos(hd, idx_q)};
          pend_d          = 1'b1;
          pend_idx_d      = idx_q - CNT_W'(1);
          idx_d           = idx_q + CNT_W'(1);
        end else begin
          pend_d         = 1'b0;
          count_d[bus_q] = n - CNT_W'(1);
          fin            = 1'b1;
          f_rc           = RC_OK;
        end
      end

      // new head handle is back from memory
      ST_HEAD: begin
        fin    = 1'b1;
        f_rc   = RC_OK;
        f_sv   = 1'b1;
        f_sh   = rd_handle_i;
        f_ret  = 1'b1;
        f_skip = skip_q;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // present the result for one cycle
    if (fin) begin
      state_d = ST_IDLE;
      done_d  = 1'b1;
      rc_d    = f_rc;
      sv_d    = f_sv;
      sh_d    = f_sh;
      fc_d    = f_fc;
      ret_d   = f_ret;
      skp_d   = f_skip;
    end
  end

  // state, per-bus pointers and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      for (int b = 0; b < BUS_COUNT; b++) begin
        count_q[b] <= '0;
        head_q[b]  <= '0;
        nfc_q[b]   <= COOKIE_W'(1);
      end
      func_q     <= FUNC_QUEUE;
      bus_q      <= '0;
      cookie_q   <= '0;
      mode_q     <= MODE_ADD;
      desc_q     <= '0;
      skip_q     <= 1'b0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      done_q     <= 1'b0;
      rc_q       <= RC_OK;
      sv_q       <= 1'b0;
      sh_q       <= '0;
      fc_q       <= '0;
      ret_q      <= 1'b0;
      skp_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      nfc_q      <= nfc_d;
      func_q     <= func_d;
      bus_q      <= bus_d;
      cookie_q   <= cookie_d;
      mode_q     <= mode_d;
      desc_q     <= desc_d;
      skip_q     <= skip_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
      done_q     <= done_d;
      rc_q       <= rc_d;
      sv_q       <= sv_d;
      sh_q       <= sh_d;
      fc_q       <= fc_d;
      ret_q      <= ret_d;
      skp_q      <= skp_d;
    end
  end

  assign done_o          = done_q;
  assign result_code_o   = rc_q;
  assign submit_valid_o  = sv_q;
  assign submit_handle_o = sh_q;
  assign first_cookie_o  = fc_q;
  assign retired_o       = ret_q;
  assign skip_rest_o     = skp_q;

endmodule

// ===== rtl/bus_transaction_queue_manager_top.sv =====
// ----------------------------------------------------------------------------
// bus_transaction_queue_manager_top
// Per-bus transaction queues held in cookie and handle RAMs
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  request   in         start & !busy       func, bus, cookie, queue_mode,
//                                           descriptor_handle, next_handle,
//                                           status, cookie_count
//  result    out        done_o (one cycle)  result_code, submit_valid,
//                                           submit_handle, first_cookie,
//                                           retired, skip_rest
//
// Reserve, add-mode queue, failed lookups on an empty queue and a completion
// that continues the head give their result in the cycle after the request.
// A retire with a following entry first does one RAM read of the new head.
// Scanning requests do at most one RAM read per queued entry, from the head; a
// cancel that removes an entry then moves each later entry one place forward.
// Reset empties all queues and sets the cookie counters to 1; the RAMs are
// not cleared. busy drops in the cycle done_o is high; results cannot stall.
module bus_transaction_queue_manager_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic        bus_i,
  input  logic [15:0] cookie_i,
  input  logic [1:0]  queue_mode_i,
  input  logic [31:0] descriptor_handle_i,
  input  logic [31:0] next_handle_i,
  input  logic        status_i,
  input  logic [15:0] cookie_count_i,
  output logic        done_o,
  output logic [1:0]  result_code_o,
  output logic        submit_valid_o,
  output logic [31:0] submit_handle_o,
  output logic [15:0] first_cookie_o,
  output logic        retired_o,
  output logic        skip_rest_o
);

  import btqm_pkg::*;

  mem_req_t            mem_req;
  logic [COOKIE_W-1:0] rd_cookie;
  logic [HANDLE_W-1:0] rd_handle;

  // sequencer
  btqm_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .func_i              (func_i),
    .bus_i               (bus_i),
    .cookie_i            (cookie_i),
    .queue_mode_i        (queue_mode_i),
    .descriptor_handle_i (descriptor_handle_i),
    .next_handle_i       (next_handle_i),
    .status_i            (status_i),
    .cookie_count_i      (cookie_count_i),
    .done_o              (done_o),
    .result_code_o       (result_code_o),
    .submit_valid_o      (submit_valid_o),
    .submit_handle_o     (submit_handle_o),
    .first_cookie_o      (first_cookie_o),
    .retired_o           (retired_o),
    .skip_rest_o         (skip_rest_o),
    .mem_req_o           (mem_req),
    .rd_cookie_i         (rd_cookie),
    .rd_handle_i         (rd_handle)
  );

  // entry cookies
  btqm_ram #(
    .WIDTH (COOKIE_W),
    .DEPTH (RAM_DEPTH)
  ) u_cookie_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.cookie_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wcookie),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_cookie)
  );

  // entry descriptor handles
  btqm_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.handle_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.whandle),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_handle)
  );

endmodule

// ===== rtl/btqm_checker.sv =====
// ----------------------------------------------------------------------------
// btqm_checker
// Port-level checks of the transaction queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btqm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func_i,
  input logic        done_o,
  input logic [1:0]  result_code_o,
  input logic        submit_valid_o,
  input logic [31:0] submit_handle_o,
  input logic [15:0] first_cookie_o,
  input logic        retired_o,
  input logic        skip_rest_o
);

  import btqm_pkg::*;

  logic fail_done;

  // result strobe of a request that did not succeed
  assign fail_done = done_o && (result_code_o != RC_OK);

  // a result frees the block for the next request in the same cycle
  `ASSERT_STD(a_done_not_busy, done_o |-> !busy)

  // a reserve request answers in the next cycle
  `ASSERT_STD(a_reserve_one_cycle, (start && !busy && (func_i == FUNC_RESERVE)) |=> done_o)

  // the handle field is zero when nothing is submitted
  `ASSERT_STD(a_submit_handle_zero, (done_o && !submit_valid_o) |-> (submit_handle_o == '0))

  // a failed request starts nothing and retires nothing
  `ASSERT_STD(a_fail_quiet, fail_done |-> (!submit_valid_o && !retired_o && (first_cookie_o == '0)))

  // skipped descriptors only come with a retirement
  `ASSERT_STD(a_skip_needs_retire, (done_o && skip_rest_o) |-> retired_o)

endmodule

bind bus_transaction_queue_manager_top btqm_checker u_btqm_checker (.*);
